// ----- hdl/pfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, register indexes and fixed-point helpers for the PID block
// with filtered derivative and anti-windup.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int DW  = 32;   // data width, Q16.16
  localparam int FB  = 16;   // fraction bits
  localparam int MW  = 34;   // multiplier operand width
  localparam int PW  = 68;   // multiplier product width
  localparam int QW  = 68;   // dividend / quotient width
  localparam int RW  = 35;   // divider remainder width
  localparam int CNW = 7;    // divider step counter width

  // ceil(2^35 / 3): floor(n / 3) = (n * RECIP3) >> 35 for n < 2^35
  localparam logic [MW-1:0] RECIP3 = 34'h2_AAAA_AAAB;

  localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [2:0] REG_GAIN_SCALE   = 3'd3;
  localparam logic [2:0] REG_DRIVE_MIN    = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX    = 3'd5;
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd6;

  localparam logic [1:0] STAT_COMPUTED = 2'd0;
  localparam logic [1:0] STAT_HELD     = 2'd1;
  localparam logic [1:0] STAT_BACKWARD = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_NUM, S_DIV, S_KP, S_KI, S_KD, S_PT, S_DV, S_SUM,
    S_P1, S_P2, S_P3, S_INC, S_AW, S_AWD, S_FIN, S_OUT
  } seq_state_e;

  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_ROUND} div_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

  // saturate a magnitude with sign to a signed 32-bit value
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [80:0] m);
    logic [80:0] lim;
    logic [31:0] vs;
    lim = neg ? 81'h8000_0000 : 81'h7FFF_FFFF;
    vs  = (m > lim) ? lim[31:0] : m[31:0];
    return neg ? $signed(~vs + 32'd1) : $signed(vs);
  endfunction

  // round half away from zero, drop fraction, saturate
  function automatic logic signed [31:0] rshift(input logic neg, input logic [67:0] m);
    logic [67:0] s;
    s = m + 68'h8000;
    return sat_mag(neg, {29'd0, s[67:16]});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < 36'shF_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clampd(input logic signed [35:0] v,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
    if (v < $signed({{4{lo[31]}}, lo})) return lo;
    if (v > $signed({{4{hi[31]}}, hi})) return hi;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pfd_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pfd_mul (
  input  wire logic                  clk_i,
  input  wire logic [pfd_pkg::MW-1:0] a_i,
  input  wire logic [pfd_pkg::MW-1:0] b_i,
  output logic      [pfd_pkg::PW-1:0] prod_o
);
  import pfd_pkg::*;

  logic [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(a_i) * PW'(b_i);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ----- hdl/pfd_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_div
// Restoring divider, one quotient bit per cycle, result rounded to nearest
// with ties away from zero. Quotient is valid while done is high.
// ----------------------------------------------------------------------------
module pfd_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [pfd_pkg::QW-1:0] num_i,
  input  wire logic [pfd_pkg::MW-1:0] den_i,
  output logic      [pfd_pkg::QW-1:0] quot_o,
  output pfd_pkg::div_status_t        stat_o
);
  import pfd_pkg::*;

  div_state_e     dstate_q, dstate_d;
  logic [CNW-1:0] cnt_q;
  logic [QW-1:0]  sh_q;
  logic [RW-1:0]  rem_q;
  logic [MW-1:0]  den_q;

  logic [RW-1:0]  remsh, remdiff, gap;
  logic           ge, rnd;

  assign remsh   = {rem_q[RW-2:0], sh_q[QW-1]};
  assign ge      = remsh >= {1'b0, den_q};
  assign remdiff = remsh - {1'b0, den_q};
  assign gap     = {1'b0, den_q} - rem_q;
  assign rnd     = rem_q >= gap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q <= DIV_IDLE;
    end else begin
      dstate_q <= dstate_d;
    end
  end

  always_comb begin
    dstate_d = dstate_q;
    unique case (dstate_q)
      DIV_IDLE:  if (start_i) dstate_d = DIV_RUN;
      DIV_RUN:   if (cnt_q == '0) dstate_d = DIV_ROUND;
      DIV_ROUND: dstate_d = DIV_IDLE;
      default:   dstate_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dstate_q == DIV_IDLE && start_i) begin
      sh_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= CNW'(QW - 1);
    end else if (dstate_q == DIV_RUN) begin
      sh_q  <= {sh_q[QW-2:0], ge};
      rem_q <= ge ? remdiff : remsh;
      cnt_q <= cnt_q - CNW'(1);
    end
  end

  assign quot_o      = sh_q + QW'(rnd);
  assign stat_o.busy = dstate_q != DIV_IDLE;
  assign stat_o.done = dstate_q == DIV_ROUND;

endmodule
`default_nettype wire

// ----- hdl/pid_filtered_deriv_antiwindup_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_filtered_deriv_antiwindup_top
// PID controller, Q16.16, derivative on measurement through a Tustin
// low-pass, conditional integration and shrink-only back-calculation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries measured, setpoint and
//   timestamp. Output channel (out_valid_o / out_stall_i) carries one drive
//   and status per input transfer. Config writes go through cfg_we_i,
//   cfg_index_i and cfg_data_i; the user must make them only while the
//   block is idle, which the block itself does not enforce. A held or
//   time-backward item goes from the check state straight to the output
//   state, which raises out_valid_o; the next input transfer can follow
//   once the sequencer is back in idle. A computed item waits on the
//   bit-serial filter divide (68 quotient steps plus rounding) and runs
//   ten products (nine when integ_gain is not positive) on one shared
//   34x34 multiplier; the divide by three is a reciprocal product.
//   One item is in work at a time; in_stall_o is high from transfer until
//   the result moves to the output register.
//   The output register lets the next item enter while a result waits.
//   If the receiver stalls and a new result is ready, the sequencer waits.
//   Reset clears all controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module pid_filtered_deriv_antiwindup_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] measured_i,
  input  wire logic signed [31:0] setpoint_i,
  input  wire logic        [31:0] timestamp_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [31:0] drive_o,
  output logic             [1:0]  status_o,
  input  wire logic               cfg_we_i,
  input  wire logic        [2:0]  cfg_index_i,
  input  wire logic        [31:0] cfg_data_i
);
  import pfd_pkg::*;

  seq_state_e state_q, state_d;

  logic signed [31:0] prop_gain_q, integ_gain_q, deriv_gain_q, gain_scale_q;
  logic signed [31:0] drive_min_q, drive_max_q;
  logic        [15:0] min_interval_q;

  logic signed [31:0] meas_q, setp_q;
  logic        [31:0] now_q;
  logic signed [31:0] integ_q, filt_q, mlast_q, dlast_q;
  logic        [31:0] tlast_q;

  logic        [31:0] dt_q;
  logic signed [31:0] err_q, kp_q, ki_q, kd_q, pterm_q, deriv_q;
  logic signed [33:0] uraw_q;
  logic               pneg_q, nneg_q, allow_q, awneg_q;
  logic        [33:0] awmag_q;
  logic        [31:0] p1hi_q;
  logic        [63:0] plo_q;
  logic        [96:0] m96_q;
  logic signed [31:0] res_drive_q, out_drive_q;
  logic        [1:0]  res_status_q, out_status_q;
  logic               out_valid_q;

  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          div_start;
  logic [QW-1:0] div_num, div_quot;
  logic [MW-1:0] div_den;
  div_status_t   div_stat;

  logic        [15:0] mi;
  logic        [18:0] t2;
  logic        [31:0] dt_now;
  logic signed [33:0] t2mdt;
  logic signed [32:0] dd;
  logic signed [67:0] pv, numv;
  logic        [67:0] nmag;
  logic signed [32:0] err_raw;
  logic signed [35:0] uraw36, usat36, diff36, aw36, fin36;
  logic signed [31:0] usat32, inc32;
  logic        [35:0] absdiff;
  logic        [31:0] negq_mag;
  logic               negq_neg, out_free;

  assign mi      = (min_interval_q == 16'd0) ? 16'd1 : min_interval_q;
  assign t2      = {mi, 3'b000};
  assign dt_now  = now_q - tlast_q;
  assign t2mdt   = $signed({15'd0, t2}) - $signed({2'd0, dt_now});
  assign dd      = $signed({meas_q[31], meas_q}) - $signed({mlast_q[31], mlast_q});
  assign pv      = $signed({1'b0, prod[66:0]});
  assign numv    = $signed({{34{dd[32]}}, dd, 1'b0}) + (pneg_q ? -pv : pv);
  assign nmag    = numv[67] ? 68'(-numv) : 68'(numv);
  assign err_raw = $signed({setp_q[31], setp_q}) - $signed({meas_q[31], meas_q});

  assign negq_mag = (filt_q == 32'sh8000_0000) ? 32'h7FFF_FFFF : mag32(filt_q);
  assign negq_neg = filt_q > 32'sd0;

  assign uraw36  = {{2{uraw_q[33]}}, uraw_q};
  assign usat32  = clampd(uraw36, drive_min_q, drive_max_q);
  assign usat36  = {{4{usat32[31]}}, usat32};
  assign diff36  = usat36 - uraw36;
  assign absdiff = diff36[35] ? 36'(-diff36) : 36'(diff36);
  // quotient of the reciprocal product is floor((|diff| + 1) / 3)
  assign aw36    = awneg_q ? -$signed({3'b000, prod[67:35]}) : $signed({3'b000, prod[67:35]});
  assign inc32   = sat_mag((err_q < 0) != (ki_q < 0), m96_q[96:16]);
  assign fin36   = $signed({{4{pterm_q[31]}}, pterm_q}) + $signed({{4{integ_q[31]}}, integ_q})
                 + $signed({{4{deriv_q[31]}}, deriv_q});

  assign out_free = !out_valid_q || !out_stall_i;

  pfd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: next state, multiplier operands, divider launch
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = nmag;
    div_den   = MW'(dt_q) + MW'(t2);
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        mul_a = MW'(mag32(filt_q));
        mul_b = t2mdt[33] ? MW'(-t2mdt) : MW'(t2mdt);
        if (now_q < tlast_q || dt_now < 32'(mi)) state_d = S_OUT;
        else state_d = S_NUM;
      end
      S_NUM: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        mul_a = MW'(mag32(prop_gain_q));
        mul_b = MW'(mag32(gain_scale_q));
        if (div_stat.done) state_d = S_KP;
      end
      S_KP: begin
        mul_a   = MW'(mag32(integ_gain_q));
        mul_b   = MW'(mag32(gain_scale_q));
        state_d = S_KI;
      end
      S_KI: begin
        mul_a   = MW'(mag32(deriv_gain_q));
        mul_b   = MW'(mag32(gain_scale_q));
        state_d = S_KD;
      end
      S_KD: begin
        mul_a   = MW'(mag32(kp_q));
        mul_b   = MW'(mag32(err_q));
        state_d = S_PT;
      end
      S_PT: begin
        mul_a   = MW'(mag32(kd_q));
        mul_b   = MW'(negq_mag);
        state_d = S_DV;
      end
      S_DV:  state_d = S_SUM;
      S_SUM: begin
        mul_a   = MW'(mag32(err_q));
        mul_b   = MW'(dt_q);
        state_d = S_P1;
      end
      S_P1: begin
        mul_a   = MW'(prod[31:0]);
        mul_b   = MW'(mag32(ki_q));
        state_d = S_P2;
      end
      S_P2: begin
        mul_a   = MW'(p1hi_q);
        mul_b   = MW'(mag32(ki_q));
        state_d = S_P3;
      end
      S_P3:  state_d = S_INC;
      S_INC: state_d = S_AW;
      S_AW: begin
        if (integ_gain_q > 32'sd0) begin
          mul_a   = awmag_q;
          mul_b   = RECIP3;
          state_d = S_AWD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_AWD: state_d = S_FIN;
      S_FIN: state_d = S_OUT;
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= '0;
      integ_gain_q   <= '0;
      deriv_gain_q   <= '0;
      gain_scale_q   <= 32'sh0001_0000;
      drive_min_q    <= '0;
      drive_max_q    <= 32'sh0064_0000;
      min_interval_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:    prop_gain_q    <= cfg_data_i;
        REG_INTEG_GAIN:   integ_gain_q   <= cfg_data_i;
        REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data_i;
        REG_GAIN_SCALE:   gain_scale_q   <= cfg_data_i;
        REG_DRIVE_MIN:    drive_min_q    <= cfg_data_i;
        REG_DRIVE_MAX:    drive_max_q    <= cfg_data_i;
        REG_MIN_INTERVAL: min_interval_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      filt_q      <= '0;
      mlast_q     <= '0;
      tlast_q     <= '0;
      dlast_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (state_q == S_OUT && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        S_CHECK: begin
          if (now_q < tlast_q) begin
            integ_q <= '0;
            tlast_q <= '0;
          end else if (dt_now >= 32'(mi)) begin
            tlast_q <= now_q;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            filt_q  <= sat_mag(nneg_q, {13'd0, div_quot});
            mlast_q <= meas_q;
          end
        end
        S_INC: begin
          if (allow_q) begin
            integ_q <= sat32({{4{integ_q[31]}}, integ_q} + {{4{inc32[31]}}, inc32});
          end
        end
        S_AW: begin
          if (!(integ_gain_q > 32'sd0)) integ_q <= '0;
        end
        S_AWD: begin
          if ((aw36 < 0 && integ_q > 0) || (aw36 > 0 && integ_q < 0)) begin
            integ_q <= sat32($signed({{4{integ_q[31]}}, integ_q}) + aw36);
          end
        end
        S_FIN: dlast_q <= clampd(fin36, drive_min_q, drive_max_q);
        default: ;
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          meas_q <= measured_i;
          setp_q <= setpoint_i;
          now_q  <= timestamp_i;
        end
      end
      S_CHECK: begin
        dt_q   <= dt_now;
        err_q  <= sat32(36'(err_raw));
        pneg_q <= filt_q[31] != t2mdt[33];
        res_drive_q  <= dlast_q;
        res_status_q <= (now_q < tlast_q) ? STAT_BACKWARD : STAT_HELD;
      end
      S_NUM: nneg_q <= numv[67];
      S_KP:  kp_q <= rshift(prop_gain_q[31] != gain_scale_q[31], prod);
      S_KI:  ki_q <= rshift(integ_gain_q[31] != gain_scale_q[31], prod);
      S_KD:  kd_q <= rshift(deriv_gain_q[31] != gain_scale_q[31], prod);
      S_PT:  pterm_q <= rshift(kp_q[31] != err_q[31], prod);
      S_DV:  deriv_q <= rshift(kd_q[31] != negq_neg, prod);
      S_SUM: begin
        uraw_q  <= 34'(fin36);
        allow_q <= !(fin36 > $signed({{4{drive_max_q[31]}}, drive_max_q}) ||
                     fin36 < $signed({{4{drive_min_q[31]}}, drive_min_q})) ||
                   (fin36 > $signed({{4{drive_max_q[31]}}, drive_max_q}) && err_q < 0) ||
                   (fin36 < $signed({{4{drive_min_q[31]}}, drive_min_q}) && err_q > 0);
      end
      S_P1: begin
        p1hi_q  <= prod[63:32];
        // back-calculation operand, from the raw sum only
        awneg_q <= diff36[35];
        awmag_q <= 34'(absdiff + 36'd1);
      end
      S_P2:  plo_q  <= prod[63:0];
      S_P3:  m96_q  <= {33'd0, plo_q} + {1'b0, prod[63:0], 32'd0} + 97'h8000;
      S_FIN: begin
        res_drive_q  <= clampd(fin36, drive_min_q, drive_max_q);
        res_status_q <= STAT_COMPUTED;
      end
      S_OUT: begin
        if (out_free) begin
          out_drive_q  <= res_drive_q;
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign status_o    = out_status_q;

`ifndef SYNTHESIS
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !div_stat.busy)
    else $error("input transfer while divider busy");
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CHECK))
    else $error("sequencer missed input transfer");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider result outside the divide wait");
`endif

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 PID controller with filtered derivative
// and anti-windup. Drives measurement/setpoint/timestamp transfers with
// random idling on both sides, predicts drive and status per transfer, and
// compares every output transfer in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
  import pfd_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam wide_t WMAX = wide_t'(32'sh7FFF_FFFF);
  localparam wide_t WMIN = wide_t'(32'sh8000_0000);

  class pid_drive_model;
    logic signed [31:0] kp_r, ki_r, kd_r, gs_r, dmin_r, dmax_r;
    logic [15:0]        mi_r;
    logic signed [31:0] integ, filt, meas_last, drive_last;
    logic [31:0]        time_last;
    logic [33:0]        drive_q[$];   // {status, drive}
    int                 errors;

    function new();
      kp_r = 0; ki_r = 0; kd_r = 0; gs_r = 32'sh0001_0000;
      dmin_r = 0; dmax_r = 32'sh0064_0000; mi_r = 16'd100;
      integ = 0; filt = 0; meas_last = 0; drive_last = 0; time_last = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_PROP_GAIN:    kp_r = val;
        REG_INTEG_GAIN:   ki_r = val;
        REG_DERIV_GAIN:   kd_r = val;
        REG_GAIN_SCALE:   gs_r = val;
        REG_DRIVE_MIN:    dmin_r = val;
        REG_DRIVE_MAX:    dmax_r = val;
        REG_MIN_INTERVAL: mi_r = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned mi_eff();
      return (mi_r == 0) ? 1 : mi_r;
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function wide_t magw(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    function logic signed [31:0] satw(wide_t v);
      if (v > WMAX) return WMAX[31:0];
      if (v < WMIN) return WMIN[31:0];
      return v[31:0];
    endfunction

    function logic signed [31:0] sat_mag(bit neg, wide_t m);
      wide_t lim, v;
      lim = neg ? -WMIN : WMAX;
      v = (m > lim) ? lim : m;
      return neg ? -v : v;
    endfunction

    // magnitude, round half away from zero, drop fraction
    function logic signed [31:0] round_q(bit neg, wide_t m);
      return sat_mag(neg, (m + 32768) >>> 16);
    endfunction

    function logic signed [31:0] mulq(logic signed [31:0] a, logic signed [31:0] b);
      return round_q((a < 0) != (b < 0), magw(wide_t'(a)) * magw(wide_t'(b)));
    endfunction

    function logic signed [31:0] clampd(wide_t v);
      if (v < dmin_r) return dmin_r;
      if (v > dmax_r) return dmax_r;
      return v[31:0];
    endfunction

    function void note_sample(logic signed [31:0] x, logic signed [31:0] sp,
                              logic [31:0] ts);
      wide_t dt, t2, num, nmag, den, qv, rem, uraw, diff, aw;
      logic signed [31:0] err, q, kp, ki, kd, deriv, pterm, usat, inc, drive;
      logic [1:0] status;
      bit nneg, hi, lo;
      if (ts < time_last) begin
        integ = 0;
        time_last = 0;
        drive = drive_last;
        status = STAT_BACKWARD;
      end else if (ts - time_last < mi_eff()) begin
        drive = drive_last;
        status = STAT_HELD;
      end else begin
        dt = ts - time_last;
        t2 = 8 * mi_eff();
        err = satw(wide_t'(sp) - wide_t'(x));
        time_last = ts;
        // Tustin filter on the measurement
        num = 2 * (wide_t'(x) - wide_t'(meas_last)) + wide_t'(filt) * (t2 - dt);
        nneg = num < 0;
        nmag = magw(num);
        den = dt + t2;
        qv = nmag / den;
        rem = nmag - qv * den;
        if (rem >= den - rem) qv = qv + 1;
        q = sat_mag(nneg, qv);
        filt = q;
        meas_last = x;
        kp = mulq(kp_r, gs_r);
        ki = mulq(ki_r, gs_r);
        kd = mulq(kd_r, gs_r);
        deriv = mulq(kd, satw(-wide_t'(q)));
        pterm = mulq(kp, err);
        uraw = wide_t'(pterm) + wide_t'(integ) + wide_t'(deriv);
        usat = clampd(uraw);
        hi = uraw > dmax_r;
        lo = uraw < dmin_r;
        if (!(hi || lo) || (hi && err < 0) || (lo && err > 0)) begin
          inc = round_q((err < 0) != (ki < 0),
                        magw(wide_t'(err)) * dt * magw(wide_t'(ki)));
          integ = satw(wide_t'(integ) + wide_t'(inc));
        end
        if (ki_r > 0) begin
          // back-calculation, only toward zero
          diff = wide_t'(usat) - uraw;
          aw = (magw(diff) + 1) / 3;
          if (diff < 0) aw = -aw;
          if ((aw < 0 && integ > 0) || (aw > 0 && integ < 0))
            integ = satw(wide_t'(integ) + aw);
        end else begin
          integ = 0;
        end
        drive = clampd(wide_t'(pterm) + wide_t'(integ) + wide_t'(deriv));
        drive_last = drive;
        status = STAT_COMPUTED;
      end
      drive_q.push_back({status, drive});
    endfunction

    function void check_drive(logic signed [31:0] d, logic [1:0] s);
      logic [33:0] exp_v;
      if (drive_q.size() == 0) begin
        $error("unexpected result: drive %h status %0d", d, s);
        errors++;
        return;
      end
      exp_v = drive_q.pop_front();
      if (d !== exp_v[31:0]) begin
        $error("drive: expected %h, got %h", exp_v[31:0], d);
        errors++;
      end
      if (s !== exp_v[33:32]) begin
        $error("status: expected %0d, got %0d", exp_v[33:32], s);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] measured = 0;
  logic signed [31:0] setpoint = 0;
  logic        [31:0] timestamp = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] drive;
  logic        [1:0]  status;
  logic               cfg_we = 0;
  logic        [2:0]  cfg_index = 0;
  logic        [31:0] cfg_data = 0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  pid_drive_model pred = new();

  pid_filtered_deriv_antiwindup_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .measured_i  (measured),
    .setpoint_i  (setpoint),
    .timestamp_i (timestamp),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .drive_o     (drive),
    .status_o    (status),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pred.check_drive(drive, status);
  end

  task automatic send(logic signed [31:0] x, logic signed [31:0] sp, logic [31:0] ts);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid  <= 1;
    measured  <= x;
    setpoint  <= sp;
    timestamp <= ts;
    do @(posedge clk); while (in_stall);
    pred.note_sample(x, sp, ts);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pred.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    pred.set_reg(idx, val);
  endtask

  task automatic configure(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] gs, logic [31:0] dmin, logic [31:0] dmax,
                           logic [31:0] mi);
    drain();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_GAIN_SCALE, gs);
    write_reg(REG_DRIVE_MIN, dmin);
    write_reg(REG_DRIVE_MAX, dmax);
    write_reg(REG_MIN_INTERVAL, mi);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_gain();
    logic [31:0] g;
    g = $urandom_range(0, 32'h0004_0000);
    return $urandom_range(1) ? -g : g;
  endfunction

  function automatic logic signed [31:0] rand_value();
    if ($urandom_range(3) == 0) return $urandom;
    return int'($urandom_range(0, 1 << 24)) - (1 << 23);
  endfunction

  task automatic random_items(int n);
    longint unsigned tl, mi, t64;
    logic signed [31:0] x, sp;
    logic [31:0] ts;
    int r;
    for (int i = 0; i < n; i++) begin
      tl = pred.time_last;
      mi = pred.mi_eff();
      r  = $urandom_range(99);
      x  = rand_value();
      sp = $urandom_range(1) ? rand_value() : x + int'($urandom_range(0, 1 << 20)) - (1 << 19);
      if (r < 84) begin
        t64 = tl + mi + $urandom_range(0, 3 * mi);
        ts = (t64 > 64'hFFFF_FFFF) ? $urandom_range(0, tl) : t64[31:0];
      end else if (r < 93) begin
        t64 = tl + $urandom_range(0, mi - 1);
        ts = (t64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t64[31:0];
      end else if (r < 97) begin
        ts = (tl == 0) ? 32'd0 : $urandom_range(0, tl - 1);
      end else begin
        ts = $urandom;
      end
      send(x, sp, ts);
    end
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    tx_idle_pct = 17;
    rx_idle_pct = 87;
    // reset settings: first sample at time zero is held
    send(0, 0, 0);
    send(32'sh0001_0000, 32'sh000A_0000, 100);
    configure(32'sh0001_0000, 32'sh0000_199A, 32'sh0000_8000, 32'sh0001_0000,
              32'shFF9C_0000, 32'sh0064_0000, 10);
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 200);
    send(32'sh8000_0000, 32'sh7FFF_FFFF, 300);
    send(32'sh8000_0000, 32'sh8000_0000, 305);   // interval too short
    send(0, 32'sh0010_0000, 320);
    send(0, 32'sh0010_0000, 320);                // zero interval
    send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send(0, 0, 5);                               // time went backward
    send(0, 32'sh0005_0000, 5);
    send(32'sh0000_FFFF, 32'shFFFF_0000, 50);
    send(32'sh5555_5555, 32'shAAAA_AAAA, 32'h5555_5555);
    send(32'shAAAA_AAAA, 32'sh5555_5555, 32'hAAAA_AAAA);
    configure(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send(32'sh0001_0000, 32'sh7FFF_FFFF, 1);
    send(32'sh8000_0000, 32'sh7FFF_FFFF, 2);
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 4);
    send(0, 0, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 17; rx_idle_pct = 87;
      end else if (ph < 4) begin
        tx_idle_pct = 87; rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      case (ph)
        0: configure(rand_gain(), rand_gain(), rand_gain(), 32'sh0001_0000,
                     32'shFF38_0000, 32'sh00C8_0000, $urandom_range(1, 200));
        1: configure(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        // crossed clamps, negative integral gain, widest interval
        2: configure(rand_gain(), 32'shFFFF_0000, rand_gain(), 32'sh8000_0000,
                     32'sh0032_0000, 32'shFFCE_0000, 16'hFFFF);
        3: configure(rand_gain(), $urandom_range(1, 32'h0002_0000), rand_gain(),
                     $urandom, 32'shFFF6_0000, 32'sh000A_0000, $urandom_range(1, 50));
        4: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: configure(rand_gain(), $urandom_range(1, 32'h0000_8000), rand_gain(),
                           32'sh0000_8000, 32'sh0000_0000, 32'sh0064_0000,
                           $urandom_range(1, 100));
      endcase
      random_items(125);
      if (ph == 2) drain();
      random_items(125);
    end

    in_valid <= 0;
    waited = 0;
    while (pred.pending() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("[pid_filtered_deriv_antiwindup_top] OK");
    end else begin
      if (pred.pending() != 0) $error("%0d results never arrived", pred.pending());
      $display("[pid_filtered_deriv_antiwindup_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[pid_filtered_deriv_antiwindup_top] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pfd_pkg.sv
hdl/pfd_mul.sv
hdl/pfd_div.sv
hdl/pid_filtered_deriv_antiwindup_top.sv
test/tb.sv
